// ===== design/fifo_free_list_node_pool_defines.svh =====
// ----------------------------------------------------------------------------
// Free list node pool: assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIFO_FREE_LIST_NODE_POOL_DEFINES_SVH
`define FIFO_FREE_LIST_NODE_POOL_DEFINES_SVH

// same-cycle implication
`define FFLNP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("free list node pool check failed");

// next-cycle implication
`define FFLNP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("free list node pool check failed");

`endif

// ===== design/fflnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Free list node pool: package
// Sizes, operation codes and status codes shared by the pool and its checker.
// ----------------------------------------------------------------------------
package fflnp_pkg;

   localparam int MAX_NODES = 512;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = IDX_W + 1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOT_USED = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

endpackage

// ===== design/fifo_free_list_node_pool.sv =====
// A request is taken in S_IDLE and its result is registered from S_EXEC,
// which waits while a held response is stalled; req_stall is high in S_EXEC,
// whose head, tail and mark update uses link and mark memory reads made in
// S_IDLE. Reset (synchronous) and every csr write start an init sweep over
// up to 512 nodes that rebuilds the free list; req_stall is high meanwhile.
// ----------------------------------------------------------------------------
// Free list node pool
// Hands out and takes back fixed-size nodes through a FIFO linked free list
// held in a link memory, with a used mark memory for put checks.
// ----------------------------------------------------------------------------
module fifo_free_list_node_pool (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fflnp_pkg::CNT_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [fflnp_pkg::IDX_W-1:0]   req_node_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [fflnp_pkg::IDX_W-1:0]   rsp_granted_index,
   output logic [fflnp_pkg::CNT_W-1:0]   rsp_free_nodes
);
   import fflnp_pkg::*;

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        free_ff, free_in;
   op_type                  op_ff, op_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]        rsp_granted_ff, rsp_granted_in;
   logic [CNT_W-1:0]        rsp_free_ff, rsp_free_in;

   logic [IDX_W-1:0]        link_mem [MAX_NODES];
   logic                    used_mem [MAX_NODES];
   logic [IDX_W-1:0]        link_rd_ff;
   logic                    used_rd_ff;

   logic                    link_we;
   logic [IDX_W-1:0]        link_waddr;
   logic [IDX_W-1:0]        link_wdata;
   logic                    used_we;
   logic [IDX_W-1:0]        used_waddr;
   logic                    used_wdata;

   logic [CNT_W-1:0]        cnt_clamp;
   logic                    in_range;
   logic                    free_zero;

   always_comb begin
      if (csr_wdata == '0) begin
         cnt_clamp = CNT_W'(1);
      end else if (csr_wdata > CNT_W'(MAX_NODES)) begin
         cnt_clamp = CNT_W'(MAX_NODES);
      end else begin
         cnt_clamp = csr_wdata;
      end
   end

   assign in_range  = {1'b0, idx_ff} < count_ff;
   assign free_zero = free_ff == '0;

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      free_in        = free_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;
      link_we        = 1'b0;
      link_waddr     = ptr_ff;
      link_wdata     = ptr_ff + 1'b1;
      used_we        = 1'b0;
      used_waddr     = ptr_ff;
      used_wdata     = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            link_we = 1'b1;
            used_we = 1'b1;
            ptr_in  = ptr_ff + 1'b1;
            if ({1'b0, ptr_ff} == count_ff - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !csr_we) begin
               op_in    = op_type'(req_op);
               idx_in   = req_node_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_granted_in = '0;
               rsp_free_in    = free_ff;
               state_in       = S_IDLE;
               if (op_ff == OP_GET) begin
                  if (free_zero) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_granted_in = head_ff;
                     head_in        = link_rd_ff;
                     used_we        = 1'b1;
                     used_waddr     = head_ff;
                     used_wdata     = 1'b1;
                     free_in        = free_ff - 1'b1;
                     rsp_free_in    = free_ff - 1'b1;
                  end
               end else begin
                  if (!in_range) begin
                     rsp_status_in = ST_RANGE;
                  end else if (!used_rd_ff) begin
                     rsp_status_in = ST_NOT_USED;
                  end else begin
                     used_we    = 1'b1;
                     used_waddr = idx_ff;
                     used_wdata = 1'b0;
                     if (free_zero) begin
                        head_in = idx_ff;
                     end else begin
                        link_we    = 1'b1;
                        link_waddr = tail_ff;
                        link_wdata = idx_ff;
                     end
                     tail_in     = idx_ff;
                     free_in     = free_ff + 1'b1;
                     rsp_free_in = free_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      if (csr_we) begin
         count_in = cnt_clamp;
         head_in  = '0;
         tail_in  = IDX_W'(cnt_clamp - 1'b1);
         free_in  = cnt_clamp;
         ptr_in   = '0;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         count_ff     <= CNT_W'(MAX_NODES);
         head_ff      <= '0;
         tail_ff      <= IDX_W'(MAX_NODES - 1);
         free_ff      <= CNT_W'(MAX_NODES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (state_ff == S_IDLE) begin
         link_rd_ff <= link_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      if (state_ff == S_IDLE) begin
         used_rd_ff <= used_mem[req_node_index];
      end
   end

   assign req_stall         = (state_ff != S_IDLE) || csr_we;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_free_nodes    = rsp_free_ff;

endmodule

// ===== design/fflnp_checker.sv =====
// ----------------------------------------------------------------------------
// Free list node pool: port checker
// Watches the pool's ports over time; bound into the pool module below.
// ----------------------------------------------------------------------------
`include "fifo_free_list_node_pool_defines.svh"

module fflnp_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [fflnp_pkg::IDX_W-1:0]   rsp_granted_index,
   input  logic [fflnp_pkg::CNT_W-1:0]   rsp_free_nodes
);
   import fflnp_pkg::*;

   `FFLNP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_index) && $stable(rsp_free_nodes))
   `FFLNP_ASSERT_NEXT(a_init_stall, csr_we, req_stall)
   `FFLNP_ASSERT_IMPL(a_fail_no_grant, rsp_valid && rsp_status != ST_OK, rsp_granted_index == '0)
   `FFLNP_ASSERT_IMPL(a_empty_zero, rsp_valid && rsp_status == ST_EMPTY, rsp_free_nodes == '0)
   `FFLNP_ASSERT_IMPL(a_free_bound, rsp_valid, rsp_free_nodes <= CNT_W'(MAX_NODES))

endmodule

bind fifo_free_list_node_pool fflnp_checker u_fflnp_checker (
   .clock             (clock),
   .reset             (reset),
   .csr_we            (csr_we),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_granted_index (rsp_granted_index),
   .rsp_free_nodes    (rsp_free_nodes)
);
